// ===== src/tdp_pkg.sv =====
package tdp_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } tdp_state_t;

endpackage

// ===== src/tdp_rem_unit.sv =====
module tdp_rem_unit #(
    parameter int VALUE_WIDTH = 31,
    parameter int DIV_WIDTH   = 17
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0]   divisor,
    output logic                   done,
    output logic [DIV_WIDTH-1:0]   remainder
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   done_reg, done_next;

    logic [DIV_WIDTH:0]     trial;
    logic [DIV_WIDTH:0]     diff;

    // One restoring step per cycle: bring down the next dividend bit and
    // subtract the divisor when it fits.
    assign trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CW'(VALUE_WIDTH);
        end else if (cnt_reg != '0) begin
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[DIV_WIDTH-1:0];
            end else begin
                rem_next = trial[DIV_WIDTH-1:0];
            end
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/trial_division_prime_test.sv =====
// Trial-division primality test.
// Input channel (s_valid/s_ready/s_value): one transaction carries the integer
// to test. s_ready is high only while the block is idle; it drops for the whole
// test after a transaction is accepted.
// Result channel (m_valid/m_ready/m_is_prime): one transaction per input, with
// m_is_prime high when the value is prime. The result sits in an output
// register, so a new value can be accepted while the previous result waits.
// Values 0 and 1 go straight to the finish state. Otherwise each trial divisor
// d = 2, 3, ... takes one bound check against the running square of d, then a
// one-bit-per-cycle remainder in the shared divider; the test ends when the
// square exceeds the value or a remainder is zero, and the finish state then
// loads the result. A new value is not taken until the previous test is done.
// If the receiver stalls, a finished result holds in the finish state until
// the output register frees up; no result is dropped.
// Reset (aresetn low, synchronous) returns the block to idle with no result
// pending.
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_prime
);

    // The divisor must reach floor(sqrt(max value)) + 1 without wrapping.
    localparam int DW  = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQW = 2 * DW;

    tdp_pkg::tdp_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [DW-1:0]          divisor_reg, divisor_next;
    logic [SQW-1:0]         square_reg, square_next;
    logic                   prime_reg, prime_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_is_prime_reg, m_is_prime_next;

    logic                   div_start;
    logic                   div_done;
    logic [DW-1:0]          div_rem;
    logic [SQW-1:0]         value_ext;

    assign value_ext = {{(SQW - VALUE_WIDTH){1'b0}}, value_reg};

    tdp_rem_unit #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .DIV_WIDTH  (DW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (value_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .remainder(div_rem)
    );

    always_comb begin
        state_next      = state_reg;
        value_next      = value_reg;
        divisor_next    = divisor_reg;
        square_next     = square_reg;
        prime_next      = prime_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_is_prime_next = m_is_prime_reg;
        div_start       = 1'b0;
        s_ready         = (state_reg == tdp_pkg::ST_IDLE);

        case (state_reg)
            tdp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    value_next   = s_value;
                    divisor_next = DW'(2);
                    square_next  = SQW'(4);
                    if (s_value[VALUE_WIDTH-1:1] == '0) begin
                        prime_next = 1'b0;
                        state_next = tdp_pkg::ST_FINISH;
                    end else begin
                        state_next = tdp_pkg::ST_CHECK;
                    end
                end
            end
            tdp_pkg::ST_CHECK: begin
                if (square_reg > value_ext) begin
                    prime_next = 1'b1;
                    state_next = tdp_pkg::ST_FINISH;
                end else begin
                    div_start  = 1'b1;
                    state_next = tdp_pkg::ST_DIVIDE;
                end
            end
            tdp_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        prime_next = 1'b0;
                        state_next = tdp_pkg::ST_FINISH;
                    end else begin
                        // (d + 1)^2 = d^2 + 2d + 1
                        divisor_next = divisor_reg + DW'(1);
                        square_next  = square_reg
                                     + {{(SQW - DW - 1){1'b0}}, divisor_reg, 1'b1};
                        state_next   = tdp_pkg::ST_CHECK;
                    end
                end
            end
            tdp_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_is_prime_next = prime_reg;
                    state_next      = tdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        value_reg      <= value_next;
        divisor_reg    <= divisor_next;
        square_reg     <= square_next;
        prime_reg      <= prime_next;
        m_is_prime_reg <= m_is_prime_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;

endmodule

// ===== src/tdp_checker.sv =====
module tdp_checker #(
    parameter int VALUE_WIDTH = 31
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [VALUE_WIDTH-1:0] s_value,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_is_prime
);

    // A stalled result keeps its flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_prime))
        else $error("stalled result changed");

    // The block is not ready in the cycle after taking a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready did not drop after a transaction");

    // No result appears in the cycle right after a value is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // Zero and one are reported as not prime via the finish state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid && (s_value[VALUE_WIDTH-1:1] == '0)
        |=> ##1 m_valid && !m_is_prime)
        else $error("zero or one not reported as not prime");

endmodule

bind trial_division_prime_test tdp_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_tdp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_value   (s_value),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_is_prime(m_is_prime)
);

// ===== bench/tb_trial_division_prime_test.sv =====
module tb_trial_division_prime_test;

    localparam int VALUE_WIDTH = 31;
    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};
    // Random values whose test would take longer than this many divisors are redrawn.
    localparam int unsigned TRIAL_BUDGET = 200;

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        bit                     is_prime;
    } verdict_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [VALUE_WIDTH-1:0] s_value;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_is_prime;

    verdict_t    pending_verdicts[$];
    verdict_t    oldest_verdict;
    int unsigned error_count = 0;
    int unsigned burst_left = 0;
    int unsigned ready_segment_left = 0;

    trial_division_prime_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_is_prime(m_is_prime)
    );

    always #5 aclk = ~aclk;

    // Trial division with the bound d <= n / d; also reports how many divisors were tried.
    function automatic bit predict_primality(input logic [VALUE_WIDTH-1:0] value,
                                             output int unsigned trials);
        longint unsigned n;
        longint unsigned d;
        n = 64'(value);
        trials = 0;
        if (n < 2) return 1'b0;
        for (d = 2; d <= n / d; d++) begin
            trials++;
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Called at a rising edge. Valid stays high on return; a following gap lowers it.
    task automatic offer_value(input logic [VALUE_WIDTH-1:0] value);
        verdict_t    verdict;
        int unsigned trials;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        verdict.value = value;
        verdict.is_prime = predict_primality(value, trials);
        pending_verdicts.push_back(verdict);
    endtask

    task automatic test_small_values();
        // Zero and one are not prime; two and three are prime with no divisor tried.
        offer_value(0);
        offer_value(1);
        offer_value(2);
        offer_value(3);
        offer_value(4);
        offer_value(5);
        offer_value(7);
    endtask

    task automatic test_loop_bound();
        // Squares of primes end exactly where d * d equals the value.
        offer_value(9);
        offer_value(25);
        offer_value(49);
        offer_value(121);
        offer_value(8);
        offer_value(35);
        offer_value(169);
        offer_value(65521);
        offer_value(65537);
    endtask

    task automatic test_field_extremes();
        offer_value(VALUE_MAX - VALUE_WIDTH'(1));
        offer_value(VALUE_MAX - VALUE_WIDTH'(2));
        offer_value(31'h4000_0000);
        offer_value(31'h5555_5555);
        offer_value(31'h2AAA_AAAA);
        // The all-ones value is prime and runs the full divisor range once.
        offer_value(VALUE_MAX);
    endtask

    task automatic test_random_values(input int unsigned count);
        logic [VALUE_WIDTH-1:0] value;
        int unsigned            trials;
        int unsigned            pick;
        repeat (count) begin
            do begin
                pick = $urandom_range(0, 99);
                if (pick < 55) value = VALUE_WIDTH'($urandom_range(0, 4095));
                else if (pick < 80) value = VALUE_WIDTH'($urandom_range(0, (1 << 20) - 1));
                else value = VALUE_WIDTH'($urandom);
                void'(predict_primality(value, trials));
            end while (trials > TRIAL_BUDGET);
            offer_value(value);
        end
    endtask

    // The receiver switches between ready and stalled segments, each picked at random, mostly of random length.
    always @(posedge aclk) begin
        if (ready_segment_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                ready_segment_left <= $urandom_range(1, 25);
            end else begin
                m_ready <= 1'b1;
                ready_segment_left <= ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(1, 40);
            end
        end else begin
            ready_segment_left <= ready_segment_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result transaction: is_prime=%0d", m_is_prime);
                error_count++;
            end else begin
                oldest_verdict = pending_verdicts.pop_front();
                if (m_is_prime !== oldest_verdict.is_prime) begin
                    $error("is_prime mismatch for value %0d: expected %0d, actual %0d",
                           oldest_verdict.value, oldest_verdict.is_prime, m_is_prime);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #80_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_value = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_small_values();
        test_loop_bound();
        test_field_extremes();
        test_random_values(80);

        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
